### sv/bcdfa_pkg.sv
// ----------------------------------------------------------------------------
// bcdfa_pkg
// Shared types, codes and helpers for the BCD date/time field adjuster.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdfa_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_INC  = 2'd0,
      REQ_DEC  = 2'd1,
      REQ_LOAD = 2'd2,
      REQ_NOP  = 2'd3
   } req_kind_type;

   // field select codes
   localparam logic [2:0] SEL_NONE   = 3'd0;
   localparam logic [2:0] SEL_YEAR   = 3'd1;
   localparam logic [2:0] SEL_MONTH  = 3'd2;
   localparam logic [2:0] SEL_DAY    = 3'd3;
   localparam logic [2:0] SEL_HOUR   = 3'd4;
   localparam logic [2:0] SEL_MINUTE = 3'd5;
   localparam logic [2:0] SEL_SECOND = 3'd6;

   // field limits
   localparam logic [6:0] YEAR_MAX   = 7'd99;
   localparam logic [6:0] MONTH_MAX  = 7'd12;
   localparam logic [6:0] DAY_MAX    = 7'd31;
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINSEC_MAX = 7'd59;

   // stored date and time, binary per field
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } date_time_type;

   // one request as held in the input register
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] sel;
      logic [7:0] year;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } request_type;

   // 17-11-27 23:59:59
   localparam date_time_type DATE_TIME_RESET = '{
      year:   7'd17,
      month:  4'd11,
      day:    5'd27,
      hour:   5'd23,
      minute: 6'd59,
      second: 6'd59
   };

   // binary 0..99 to packed bcd, tens by reciprocal multiply (205 / 2048)
   function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

### sv/bcdfa_next.sv
// ----------------------------------------------------------------------------
// bcdfa_next
// Next date/time from the stored value and one request: load with range
// fix-up, or a wrapping step of one selected field.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdfa_next
   import bcdfa_pkg::*;
(
   input  wire date_time_type cur,
   input  wire request_type   req,
   output date_time_type      nxt
);

   // wrapping step of a field value between lo and hi
   function automatic logic [6:0] step_value(input logic [6:0] v, input logic [6:0] lo,
                                              input logic [6:0] hi, input logic up);
      logic [6:0] dn;
      dn = v - 7'd1;
      if (up) begin
         return (v >= hi) ? lo : v + 7'd1;
      end
      if (v <= lo) begin
         return hi;
      end
      return (dn > hi) ? hi : dn;
   endfunction

   logic [6:0] day_lim;
   logic       up;
   logic [6:0] year_step, month_step, day_step, hour_step, minute_step, second_step;
   date_time_type loaded;

   // day limit from the stored month and year
   always_comb begin
      if (cur.month == 4'd4 || cur.month == 4'd6 || cur.month == 4'd9 ||
          cur.month == 4'd11) begin
         day_lim = 7'd30;
      end else if (cur.month == 4'd2) begin
         day_lim = (cur.year[1:0] != 2'd0) ? 7'd28 : 7'd29;
      end else begin
         day_lim = DAY_MAX;
      end
   end

   // stepped candidates for every field
   assign up          = (req.kind == REQ_INC);
   assign year_step   = step_value(cur.year, 7'd0, YEAR_MAX, up);
   assign month_step  = step_value(7'(cur.month), 7'd1, MONTH_MAX, up);
   assign day_step    = step_value(7'(cur.day), 7'd1, day_lim, up);
   assign hour_step   = step_value(7'(cur.hour), 7'd0, HOUR_MAX, up);
   assign minute_step = step_value(7'(cur.minute), 7'd0, MINSEC_MAX, up);
   assign second_step = step_value(7'(cur.second), 7'd0, MINSEC_MAX, up);

   // load values with out-of-range replacement
   always_comb begin
      loaded.year   = (req.year   > 8'(YEAR_MAX))   ? 7'd0 : req.year[6:0];
      loaded.month  = (req.month  > 8'(MONTH_MAX))  ? 4'd1 : req.month[3:0];
      loaded.day    = (req.day    > 8'(DAY_MAX))    ? 5'd1 : req.day[4:0];
      loaded.hour   = (req.hour   > 8'(HOUR_MAX))   ? 5'd0 : req.hour[4:0];
      loaded.minute = (req.minute > 8'(MINSEC_MAX)) ? 6'd0 : req.minute[5:0];
      loaded.second = (req.second > 8'(MINSEC_MAX)) ? 6'd0 : req.second[5:0];
   end

   // select the new value
   always_comb begin
      nxt = cur;
      unique case (req.kind)
         REQ_LOAD: nxt = loaded;
         REQ_INC, REQ_DEC: begin
            unique case (req.sel)
               SEL_YEAR:   nxt.year   = year_step;
               SEL_MONTH:  nxt.month  = month_step[3:0];
               SEL_DAY:    nxt.day    = day_step[4:0];
               SEL_HOUR:   nxt.hour   = hour_step[4:0];
               SEL_MINUTE: nxt.minute = minute_step[5:0];
               SEL_SECOND: nxt.second = second_step[5:0];
               default:    nxt = cur;
            endcase
         end
         default: nxt = cur;
      endcase
   end

endmodule

`default_nettype wire

### sv/bcd_date_time_field_adjust.sv
// ----------------------------------------------------------------------------
// bcd_date_time_field_adjust
// BCD date/time register with load and per-field up/down adjust.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  req_*   | in  | tuser {field_sel, req_type}, tdata six binary load values
//  rsp_*   | out | tdata six packed bcd fields after the request
//
//  One request per cycle sustained while the result side is ready; a request
//  passes through the input register, then the result register.
//  The stored value advances when a request moves into the result register.
//  A stalled result holds the pipeline; the input register still takes one
//  more request while the result waits.
//  Reset loads 17-11-27 23:59:59 and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_date_time_field_adjust
   import bcdfa_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,  // load_year, load_month, load_day,
                                   // load_hour, load_minute, load_second
   input  wire  [4:0]  req_tuser,  // req_type, field_sel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata   // year_bcd, month_bcd, day_bcd, hour_bcd,
                                   // minute_bcd, second_bcd, one zero pad bit
);

   logic          req_valid_ff, req_valid_in;
   request_type   req_ff, req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;
   date_time_type state_ff, state_in;
   date_time_type state_next;
   logic          advance;
   logic [7:0]    year_b, month_b, day_b, hour_b, minute_b, second_b;

   // pipeline handshake
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // input register
   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
         req_in.kind   = req_tuser[1:0];
         req_in.sel    = req_tuser[4:2];
         req_in.year   = req_tdata[7:0];
         req_in.month  = req_tdata[15:8];
         req_in.day    = req_tdata[23:16];
         req_in.hour   = req_tdata[31:24];
         req_in.minute = req_tdata[39:32];
         req_in.second = req_tdata[47:40];
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   bcdfa_next u_next (
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_next)
   );

   // bcd conversion of the new value
   assign year_b   = bin_to_bcd(state_next.year);
   assign month_b  = bin_to_bcd(7'(state_next.month));
   assign day_b    = bin_to_bcd(7'(state_next.day));
   assign hour_b   = bin_to_bcd(7'(state_next.hour));
   assign minute_b = bin_to_bcd(7'(state_next.minute));
   assign second_b = bin_to_bcd(7'(state_next.second));

   // state and result register
   always_comb begin
      state_in     = state_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         state_in     = state_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, second_b[6:0], minute_b[6:0], hour_b[5:0],
                         day_b[5:0], month_b[4:0], year_b};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= DATE_TIME_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### bench/tb_bcd_date_time_field_adjust.sv
// ----------------------------------------------------------------------------
// tb_bcd_date_time_field_adjust
// Self-checking bench for the BCD date/time field adjuster. Requests go in
// as bursts with random gaps while the result side stalls in its own
// pattern. A local calendar model tracks the stored date and time and
// predicts the six BCD fields of every result, which are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bcd_date_time_field_adjust;
   import bcdfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // field select code that no field uses
   localparam logic [2:0] SEL_UNUSED = 3'd7;

   localparam int unsigned RANDOM_ITEMS   = 1125;
   localparam int unsigned DRAIN_EVERY    = 300;
   localparam int unsigned MAX_REPORTED   = 10;
   localparam int unsigned TAIL_CYCLES    = 10;

   typedef struct packed {
      logic [6:0] second;
      logic [6:0] minute;
      logic [5:0] hour;
      logic [5:0] day;
      logic [4:0] month;
      logic [7:0] year;
   } bcd_face_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN_FLIP,
      RX_MOSTLY_STALLED
   } rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // load_year, load_month, load_day,
                                 // load_hour, load_minute, load_second
   logic [4:0]  req_tuser = '0;  // req_type, field_sel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // year_bcd, month_bcd, day_bcd, hour_bcd,
                                 // minute_bcd, second_bcd, zero pad bit

   // binary value of each stored field, indexed by field select code
   int unsigned  calendar [SEL_YEAR:SEL_SECOND];
   bcd_face_type expected_faces [$];
   int unsigned  mismatch_count = 0;
   int unsigned  burst_left = 0;

   bcd_date_time_field_adjust dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // calendar model
   // ------------------------------------------------------------------------

   function automatic logic [7:0] to_bcd(input int unsigned v);
      logic [3:0] tens;
      logic [3:0] ones;
      tens = 4'((v / 10) % 10);
      ones = 4'(v % 10);
      return {tens, ones};
   endfunction

   // last day of the stored month; month zero counts as a long month
   function automatic int unsigned month_length();
      int unsigned m;
      m = calendar[SEL_MONTH];
      if (m == 4 || m == 6 || m == 9 || m == 11)
         return 30;
      if (m == 2)
         return (calendar[SEL_YEAR] % 4 == 0) ? 29 : 28;
      return 31;
   endfunction

   function automatic int unsigned clamp_load(input logic [7:0] v,
                                              input logic [6:0] top,
                                              input int unsigned fallback);
      return (v > top) ? fallback : int'(v);
   endfunction

   // apply one request and queue the face it should produce
   function automatic void advance_calendar(input request_type rq);
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  v;
      bcd_face_type face;
      if (rq.kind == REQ_LOAD) begin
         calendar[SEL_YEAR]   = clamp_load(rq.year,   YEAR_MAX,   0);
         calendar[SEL_MONTH]  = clamp_load(rq.month,  MONTH_MAX,  1);
         calendar[SEL_DAY]    = clamp_load(rq.day,    DAY_MAX,    1);
         calendar[SEL_HOUR]   = clamp_load(rq.hour,   HOUR_MAX,   0);
         calendar[SEL_MINUTE] = clamp_load(rq.minute, MINSEC_MAX, 0);
         calendar[SEL_SECOND] = clamp_load(rq.second, MINSEC_MAX, 0);
      end else if ((rq.kind == REQ_INC || rq.kind == REQ_DEC) &&
                   rq.sel >= SEL_YEAR && rq.sel <= SEL_SECOND) begin
         lo = 0;
         case (rq.sel)
            SEL_YEAR:  hi = YEAR_MAX;
            SEL_MONTH: begin
               lo = 1;
               hi = MONTH_MAX;
            end
            SEL_DAY: begin
               lo = 1;
               hi = month_length();
            end
            SEL_HOUR:  hi = HOUR_MAX;
            default:   hi = MINSEC_MAX;
         endcase
         v = calendar[rq.sel];
         if (rq.kind == REQ_INC) begin
            v = (v >= hi) ? lo : v + 1;
         end else if (v <= lo) begin
            v = hi;
         end else begin
            v = v - 1;
            if (v > hi)
               v = hi;
         end
         calendar[rq.sel] = v;
      end
      face.year   = to_bcd(calendar[SEL_YEAR]);
      face.month  = 5'(to_bcd(calendar[SEL_MONTH]));
      face.day    = 6'(to_bcd(calendar[SEL_DAY]));
      face.hour   = 6'(to_bcd(calendar[SEL_HOUR]));
      face.minute = 7'(to_bcd(calendar[SEL_MINUTE]));
      face.second = 7'(to_bcd(calendar[SEL_SECOND]));
      expected_faces.push_back(face);
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED)
         $display("mismatch at %0t: %s", $realtime, what);
   endfunction

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v)
         note_mismatch($sformatf("%s expected %h actual %h", name, exp_v, act_v));
   endfunction

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      bcd_face_type exp_face;
      bcd_face_type act_face;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act_face = rsp_tdata[38:0];
         if (expected_faces.size() == 0) begin
            note_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            exp_face = expected_faces.pop_front();
            check_field("year_bcd",   exp_face.year,   act_face.year);
            check_field("month_bcd",  exp_face.month,  act_face.month);
            check_field("day_bcd",    exp_face.day,    act_face.day);
            check_field("hour_bcd",   exp_face.hour,   act_face.hour);
            check_field("minute_bcd", exp_face.minute, act_face.minute);
            check_field("second_bcd", exp_face.second, act_face.second);
         end
      end
   end

   // receiver back-pressure, switching between open, random and choked phases
   always @(negedge clock) begin
      static rx_mode_type rx_mode = RX_OPEN;
      static int unsigned rx_phase_left = 0;
      if (rx_phase_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_phase_left = $urandom_range(20, 200);
      end else begin
         rx_phase_left--;
      end
      case (rx_mode)
         RX_OPEN:      rsp_tready <= 1'b1;
         RX_COIN_FLIP: rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   function automatic request_type make_request(input req_kind_type kind,
                                                input logic [2:0] sel,
                                                input int unsigned y, input int unsigned mo,
                                                input int unsigned d, input int unsigned h,
                                                input int unsigned mi,
                                                input int unsigned s);
      request_type rq;
      rq.kind   = kind;
      rq.sel    = sel;
      rq.year   = 8'(y);
      rq.month  = 8'(mo);
      rq.day    = 8'(d);
      rq.hour   = 8'(h);
      rq.minute = 8'(mi);
      rq.second = 8'(s);
      return rq;
   endfunction

   // drive one request from a falling edge until it is taken
   task automatic send_request(input request_type rq);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {rq.sel, rq.kind};
      req_tdata  <= {rq.second, rq.minute, rq.hour, rq.day, rq.month, rq.year};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_calendar(rq);
      burst_left--;
      @(negedge clock);
   endtask

   // hold off until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_faces.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic step(input req_kind_type kind, input logic [2:0] sel);
      send_request(make_request(kind, sel, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
   endtask

   task automatic load(input int unsigned y, input int unsigned mo,
                       input int unsigned d, input int unsigned h,
                       input int unsigned mi, input int unsigned s);
      send_request(make_request(REQ_LOAD, 3'($urandom_range(0, 7)), y, mo, d, h, mi, s));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset value read back through a request that changes nothing
   task automatic test_reset_value();
      step(REQ_NOP, SEL_NONE);
   endtask

   // unused request and select codes leave the fields alone
   task automatic test_unused_codes();
      step(REQ_INC, SEL_NONE);
      step(REQ_DEC, SEL_UNUSED);
      step(REQ_NOP, SEL_DAY);
   endtask

   // load at the top of every range and far beyond it
   task automatic test_load_limits();
      load(99, 12, 31, 23, 59, 59);
      load(255, 255, 255, 255, 255, 255);
      load(99, 12, 31, 23, 59, 59);
   endtask

   // each field wraps past its top going up and past its bottom going down
   task automatic test_field_wrap();
      logic [2:0] sel;
      for (sel = SEL_YEAR; sel <= SEL_SECOND; sel++)
         step(REQ_INC, sel);
      for (sel = SEL_YEAR; sel <= SEL_SECOND; sel++)
         step(REQ_DEC, sel);
   endtask

   // month zero, day zero and days beyond the month's end
   task automatic test_day_limits();
      load(0, 0, 0, 0, 0, 0);
      step(REQ_DEC, SEL_DAY);
      step(REQ_INC, SEL_MONTH);
      load(4, 0, 0, 12, 30, 30);
      step(REQ_INC, SEL_DAY);
      step(REQ_DEC, SEL_MONTH);
      load(4, 2, 31, 1, 1, 1);
      step(REQ_INC, SEL_DAY);
      load(3, 2, 31, 1, 1, 1);
      step(REQ_DEC, SEL_DAY);
   endtask

   function automatic int unsigned load_value(input int unsigned lo, input int unsigned hi);
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(lo, hi);
   endfunction

   // mostly loads and single steps with a bias toward the day field
   task automatic test_random_mix();
      request_type rq;
      int unsigned pick;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         rq = make_request(REQ_INC, SEL_NONE, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            rq.kind   = REQ_LOAD;
            rq.sel    = 3'($urandom_range(0, 7));
            rq.year   = 8'(load_value(0, 99));
            rq.month  = ($urandom_range(0, 2) == 0) ? 8'd2 : 8'(load_value(0, 12));
            rq.day    = ($urandom_range(0, 1) == 0) ? 8'(load_value(26, 31))
                                                    : 8'(load_value(0, 31));
            rq.hour   = 8'(load_value(0, 23));
            rq.minute = 8'(load_value(0, 59));
            rq.second = 8'(load_value(0, 59));
         end else if (pick < 92) begin
            rq.kind = ($urandom_range(0, 1) == 0) ? REQ_INC : REQ_DEC;
            rq.sel  = ($urandom_range(0, 9) < 4) ? SEL_DAY : 3'($urandom_range(1, 6));
         end else begin
            rq.kind = req_kind_type'($urandom_range(0, 3));
            rq.sel  = 3'($urandom_range(0, 7));
         end
         send_request(rq);
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
            wait_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      calendar[SEL_YEAR]   = 17;
      calendar[SEL_MONTH]  = 11;
      calendar[SEL_DAY]    = 27;
      calendar[SEL_HOUR]   = 23;
      calendar[SEL_MINUTE] = 59;
      calendar[SEL_SECOND] = 59;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_value();
      test_unused_codes();
      test_load_limits();
      test_field_wrap();
      wait_drained();
      test_day_limits();
      test_random_mix();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_faces.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
